>>> hw/rtl/assert_macros.svh
// Assertion macros for the rotator checkers.
// Each use expects clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every edge out of reset.
`define QPR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent/consequent pair, overlapped or not as written in the property.
`define QPR_ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> hw/rtl/qpr_pkg.sv
package qpr_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int CFG_WIDTH   = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int Q30         = 30;
  localparam int COEF_W      = 32;               // holds [-2^30, 2^30]
  localparam int QPROD_W     = 34;               // rounded product of two registers
  localparam int QSUM_W      = 36;               // coefficient before clamp
  localparam int PROD_W      = COEF_W + COORD_WIDTH;
  localparam int ACC_W       = PROD_W + 2;
  localparam int RES_W       = ACC_W - Q30;

  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

  localparam logic signed [2*CFG_WIDTH-1:0] HALF_QP  = (2*CFG_WIDTH)'(1) << (Q30 - 1);
  localparam logic signed [ACC_W-1:0]       HALF_ACC = ACC_W'(1) << (Q30 - 1);
  localparam logic signed [QSUM_W-1:0]      COEF_MAX = QSUM_W'(1) << Q30;
  localparam logic signed [QSUM_W-1:0]      COEF_MIN = -COEF_MAX;
  localparam logic signed [RES_W-1:0] SAT_HI =
    {{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_LO =
    {{(RES_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROT_W = 2'd0,
    REG_ROT_X = 2'd1,
    REG_ROT_Y = 2'd2,
    REG_ROT_Z = 2'd3
  } cfg_reg_e;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef coef_t [8:0]                   coef_mat_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   in_last;
  } in_beat_t;

  typedef struct packed {
    coord_t rot_pos_x;
    coord_t rot_pos_y;
    coord_t rot_pos_z;
    logic   out_last;
  } out_beat_t;

  typedef struct packed {
    logic settled;   // matrix matches the registers, input may be taken
  } coef_stat_t;

  // floor((a*b + 2^29) / 2^30)
  function automatic logic signed [QPROD_W-1:0] mul_q30(
    input logic signed [CFG_WIDTH-1:0] a,
    input logic signed [CFG_WIDTH-1:0] b
  );
    logic signed [2*CFG_WIDTH-1:0] p;
    p = a * b;
    return QPROD_W'((p + HALF_QP) >>> Q30);
  endfunction

  function automatic coef_t clamp_coef(input logic signed [QSUM_W-1:0] c);
    logic signed [QSUM_W-1:0] r;
    r = c;
    if (c > COEF_MAX) r = COEF_MAX;
    if (c < COEF_MIN) r = COEF_MIN;
    return COEF_W'(r);
  endfunction

  function automatic coord_t sat_coord(input logic signed [RES_W-1:0] v);
    logic signed [RES_W-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return COORD_WIDTH'(r);
  endfunction

endpackage

>>> hw/rtl/qpr_coef_unit.sv
// Quaternion registers and the two-stage expansion into the rotation matrix.
module qpr_coef_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [qpr_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [qpr_pkg::CFG_WIDTH-1:0]         cfg_data,
  output qpr_pkg::coef_mat_t                    coef,
  output qpr_pkg::coef_stat_t                   stat
);

  logic signed [qpr_pkg::CFG_WIDTH-1:0] rot_w, rot_x, rot_y, rot_z;
  logic signed [qpr_pkg::QPROD_W-1:0]   ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [qpr_pkg::QSUM_W-1:0]    msum [9];
  logic [qpr_pkg::SETTLE_W-1:0]         settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_w  <= qpr_pkg::CFG_WIDTH'(1) << qpr_pkg::Q30;
      rot_x  <= '0;
      rot_y  <= '0;
      rot_z  <= '0;
      settle <= qpr_pkg::SETTLE_CYCLES;
    end else begin
      if (cfg_we) begin
        settle <= qpr_pkg::SETTLE_CYCLES;
        unique case (qpr_pkg::cfg_reg_e'(cfg_index))
          qpr_pkg::REG_ROT_W: rot_w <= cfg_data;
          qpr_pkg::REG_ROT_X: rot_x <= cfg_data;
          qpr_pkg::REG_ROT_Y: rot_y <= cfg_data;
          qpr_pkg::REG_ROT_Z: rot_z <= cfg_data;
        endcase
      end else if (settle != '0) begin
        settle <= settle - 1'b1;
      end
    end
  end

  // stage a: ten rounded products
  always_ff @(posedge clk) begin
    ww <= qpr_pkg::mul_q30(rot_w, rot_w);
    xx <= qpr_pkg::mul_q30(rot_x, rot_x);
    yy <= qpr_pkg::mul_q30(rot_y, rot_y);
    zz <= qpr_pkg::mul_q30(rot_z, rot_z);
    xy <= qpr_pkg::mul_q30(rot_x, rot_y);
    xz <= qpr_pkg::mul_q30(rot_x, rot_z);
    yz <= qpr_pkg::mul_q30(rot_y, rot_z);
    wx <= qpr_pkg::mul_q30(rot_w, rot_x);
    wy <= qpr_pkg::mul_q30(rot_w, rot_y);
    wz <= qpr_pkg::mul_q30(rot_w, rot_z);
  end

  always_comb begin
    msum[0] = qpr_pkg::QSUM_W'(ww) + qpr_pkg::QSUM_W'(xx)
            - qpr_pkg::QSUM_W'(yy) - qpr_pkg::QSUM_W'(zz);
    msum[1] = (qpr_pkg::QSUM_W'(xy) - qpr_pkg::QSUM_W'(wz)) <<< 1;
    msum[2] = (qpr_pkg::QSUM_W'(xz) + qpr_pkg::QSUM_W'(wy)) <<< 1;
    msum[3] = (qpr_pkg::QSUM_W'(xy) + qpr_pkg::QSUM_W'(wz)) <<< 1;
    msum[4] = qpr_pkg::QSUM_W'(ww) - qpr_pkg::QSUM_W'(xx)
            + qpr_pkg::QSUM_W'(yy) - qpr_pkg::QSUM_W'(zz);
    msum[5] = (qpr_pkg::QSUM_W'(yz) - qpr_pkg::QSUM_W'(wx)) <<< 1;
    msum[6] = (qpr_pkg::QSUM_W'(xz) - qpr_pkg::QSUM_W'(wy)) <<< 1;
    msum[7] = (qpr_pkg::QSUM_W'(yz) + qpr_pkg::QSUM_W'(wx)) <<< 1;
    msum[8] = qpr_pkg::QSUM_W'(ww) - qpr_pkg::QSUM_W'(xx)
            - qpr_pkg::QSUM_W'(yy) + qpr_pkg::QSUM_W'(zz);
  end

  // stage b: clamped coefficients
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      coef[i] <= qpr_pkg::clamp_coef(msum[i]);
    end
  end

  // also low in the write cycle itself
  assign stat.settled = (settle == '0) && !cfg_we;

endmodule

>>> hw/rtl/qpr_mac_pipe.sv
// Matrix-vector product: multiply, sum, round and saturate, one stage each.
module qpr_mac_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  qpr_pkg::in_beat_t   in_beat,
  output logic                pipe_ready,
  input  qpr_pkg::coef_mat_t  coef,
  output logic                out_valid,
  input  logic                out_ready,
  output qpr_pkg::out_beat_t  out_beat
);

  logic signed [qpr_pkg::PROD_W-1:0] prod [9];
  logic signed [qpr_pkg::PROD_W-1:0] prod_next [9];
  logic signed [qpr_pkg::ACC_W-1:0]  acc [3];
  logic signed [qpr_pkg::ACC_W-1:0]  acc_next [3];
  logic signed [qpr_pkg::RES_W-1:0]  res [3];
  qpr_pkg::coord_t                   pos [3];
  logic v1, v2, v3, last1, last2;
  logic adv1, adv2, adv3;

  assign adv3       = !v3 || out_ready;
  assign adv2       = !v2 || adv3;
  assign adv1       = !v1 || adv2;
  assign pipe_ready = adv1;

  assign pos[0] = in_beat.pos_x;
  assign pos[1] = in_beat.pos_y;
  assign pos[2] = in_beat.pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_next[3*i+j] = $signed(coef[3*i+j]) * pos[j];
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc_next[i] = qpr_pkg::ACC_W'(prod[3*i]) + qpr_pkg::ACC_W'(prod[3*i+1])
                  + qpr_pkg::ACC_W'(prod[3*i+2]) + qpr_pkg::HALF_ACC;
      res[i]      = qpr_pkg::RES_W'(acc[i] >>> qpr_pkg::Q30);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= load;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && load) begin
      prod  <= prod_next;
      last1 <= in_beat.in_last;
    end
    if (adv2 && v1) begin
      acc   <= acc_next;
      last2 <= last1;
    end
    if (adv3 && v2) begin
      out_beat.rot_pos_x <= qpr_pkg::sat_coord(res[0]);
      out_beat.rot_pos_y <= qpr_pkg::sat_coord(res[1]);
      out_beat.rot_pos_z <= qpr_pkg::sat_coord(res[2]);
      out_beat.out_last  <= last2;
    end
  end

  assign out_valid = v3;

endmodule

>>> hw/rtl/quaternion_point_rotator_unit.sv
// Quaternion point rotator. Software loads a unit quaternion (Q2.30) through
// the write port: index 0 rot_w = cos(angle/2), 1..3 rot_x/y/z = axis times
// sin(angle/2); reset gives the identity. Each input beat carries a Q16.16
// point and a last marker; each output beat carries the rotated point,
// rounded half up and saturated, with the marker copied. One beat is taken
// per clock, sustained, while out_ready stays high and the matrix is settled;
// the beat is loaded into the multiply stage at acceptance and then passes
// the sum and round/saturate stages of the matrix pipeline; out_valid rises
// when the last of them is loaded. The quaternion is expanded into the 3x3
// matrix by a two-stage unit, so in_ready stays low in the cycle of a register
// write and while the matrix settles after it, and likewise after reset. The
// quaternion is used as loaded: no normalisation is applied.
module quaternion_point_rotator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  qpr_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output qpr_pkg::out_beat_t              out_data,
  input  logic                            cfg_we,
  input  logic [qpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [qpr_pkg::CFG_WIDTH-1:0]   cfg_data
);

  qpr_pkg::coef_mat_t  coef;
  qpr_pkg::coef_stat_t coef_stat;
  logic                pipe_ready;

  // matrix from the registers; settled drops while it catches up
  qpr_coef_unit u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef),
    .stat      (coef_stat)
  );

  // beat accepted only once the matrix is current and stage 1 can load
  assign in_ready = pipe_ready && coef_stat.settled;

  // three-stage product pipeline; the last stage is the output register
  qpr_mac_pipe u_mac (
    .clk        (clk),
    .rst        (rst),
    .load       (in_valid && in_ready),
    .in_beat    (in_data),
    .pipe_ready (pipe_ready),
    .coef       (coef),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_data)
  );

endmodule

>>> hw/rtl/qpr_checker.sv
`include "assert_macros.svh"

module qpr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input qpr_pkg::out_beat_t              out_data,
  input logic                            cfg_we
);

  // a pending result beat is neither withdrawn nor changed
  `QPR_ASSERT_PROP(a_out_hold, (out_valid && !out_ready |=> out_valid), "out_valid dropped")
  `QPR_ASSERT_PROP(a_out_stable, (out_valid && !out_ready |=> $stable(out_data)), "out_data moved")

  // no point taken while a register is being written
  `QPR_ASSERT_ALWAYS(a_cfg_block, (!(cfg_we && in_ready)), "in_ready during write")

  // in_ready stays low while the matrix settles after a write
  `QPR_ASSERT_PROP(a_cfg_settle, (cfg_we |=> !in_ready ##1 !in_ready), "ready before settle")

  // pipeline empty straight after reset
  `QPR_ASSERT_PROP(a_reset_empty, ($past(rst) |-> !out_valid), "output after reset")

endmodule

bind quaternion_point_rotator_unit qpr_checker u_qpr_checker (.*);
